@@ hdl/genotype_column_partition_cost_macros.svh @@
// ============================================================================
// Assertion macros for the genotype column cost engine
// Shared property forms used by the RTL checks.
// ============================================================================
`ifndef GENOTYPE_COLUMN_PARTITION_COST_MACROS_SVH
`define GENOTYPE_COLUMN_PARTITION_COST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GCPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcpc assertion failed");

`endif

@@ hdl/gcpc_pkg.sv @@
// ============================================================================
// gcpc_pkg
// Types, constants and cost functions of the genotype column cost engine.
// ============================================================================
package gcpc_pkg;

    localparam int MAX_ENTRIES     = 64;
    localparam int MAX_PARTITIONS  = 16;
    localparam int MAX_INDIVIDUALS = 16;
    localparam int MAX_PLOIDY      = 8;

    localparam logic [31:0] COST_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_LOAD_ENTRY = 3'd0,
        OP_LOAD_MAP   = 3'd1,
        OP_SET_PART   = 3'd2,
        OP_FLIP       = 3'd3,
        OP_GET_COST   = 3'd4
    } t_op;

    localparam logic [1:0] CFG_PLOIDY     = 2'd0;
    localparam logic [1:0] CFG_PART_COUNT = 2'd1;
    localparam logic [1:0] CFG_COL_LENGTH = 2'd2;

    localparam logic [1:0] KIND_REF = 2'd1;
    localparam logic [1:0] KIND_ALT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] qual;
        logic [3:0]  indiv;
        logic [2:0]  digit;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETNEXT,
        S_DIV,
        S_EDAT,
        S_MAP,
        S_MAPW,
        S_ACC,
        S_PASS,
        S_QRD,
        S_QOUT
    } t_state;

    // Match cost in 16-bit fixed point with 8 fraction bits: round(256 * -10*log10(1 - 10^(-q/10))).
    function automatic logic [15:0] match_cost(input logic [15:0] q);
        logic [15:0] c;
        c = 16'd0;
        if (q < 16'd34) begin
            unique case (q[5:0])
                6'd0:  c = 16'd10240;
                6'd1:  c = 16'd1758;
                6'd2:  c = 16'd1108;
                6'd3:  c = 16'd773;
                6'd4:  c = 16'd564;
                6'd5:  c = 16'd423;
                6'd6:  c = 16'd322;
                6'd7:  c = 16'd247;
                6'd8:  c = 16'd192;
                6'd9:  c = 16'd150;
                6'd10: c = 16'd117;
                6'd11: c = 16'd92;
                6'd12: c = 16'd72;
                6'd13: c = 16'd57;
                6'd14: c = 16'd45;
                6'd15: c = 16'd36;
                6'd16: c = 16'd28;
                6'd17: c = 16'd22;
                6'd18: c = 16'd18;
                6'd19: c = 16'd14;
                6'd20: c = 16'd11;
                6'd21: c = 16'd9;
                6'd22: c = 16'd7;
                6'd23: c = 16'd6;
                6'd24: c = 16'd4;
                6'd25: c = 16'd4;
                6'd26: c = 16'd3;
                6'd27: c = 16'd2;
                6'd28: c = 16'd2;
                6'd29: c = 16'd1;
                6'd30: c = 16'd1;
                6'd31: c = 16'd1;
                6'd32: c = 16'd1;
                6'd33: c = 16'd1;
                default: c = 16'd0;
            endcase
        end
        return c;
    endfunction

    // floor(2^32 / p) for divisors 2 to 8.
    function automatic logic [31:0] recip(input logic [3:0] p);
        logic [31:0] m;
        unique case (p)
            4'd2:    m = 32'h8000_0000;
            4'd3:    m = 32'h5555_5555;
            4'd4:    m = 32'h4000_0000;
            4'd5:    m = 32'h3333_3333;
            4'd6:    m = 32'h2AAA_AAAA;
            4'd7:    m = 32'h2492_4924;
            4'd8:    m = 32'h2000_0000;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? COST_MAX : s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? (a - b) : 32'd0;
    endfunction

endpackage

@@ hdl/gcpc_ram.sv @@
// ============================================================================
// gcpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module gcpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/gcpc_divp.sv @@
// ============================================================================
// gcpc_divp
// Splits off one base-p digit: quotient and remainder of a 32-bit word by a
// divisor of 1 to 8, by reciprocal multiplication and one correction step.
// ============================================================================
module gcpc_divp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_word,
    input  logic [3:0]  i_pl,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [2:0]  o_rem
);

    logic [31:0] r_w;
    logic [3:0]  r_p;
    logic [31:0] r_m;
    logic [63:0] r_prod;
    logic        r_s1;
    logic        r_s2;
    logic        r_done;
    logic [31:0] r_quot;
    logic [2:0]  r_rem;

    logic [31:0] q_est;
    logic [31:0] qp;
    logic [31:0] rem_est;
    logic [31:0] n_quot;
    logic [31:0] n_rem;

    // The estimate is never above the true quotient and at most one below it.
    always_comb begin
        q_est   = r_prod[63:32];
        qp      = q_est * {28'd0, r_p};
        rem_est = r_w - qp;
        if (r_p == 4'd1) begin
            n_quot = r_w;
            n_rem  = 32'd0;
        end else if (rem_est >= {28'd0, r_p}) begin
            n_quot = q_est + 32'd1;
            n_rem  = rem_est - {28'd0, r_p};
        end else begin
            n_quot = q_est;
            n_rem  = rem_est;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_s2   <= r_s1;
            r_done <= r_s2;
        end
        if (i_start) begin
            r_w <= i_word;
            r_p <= i_pl;
            r_m <= gcpc_pkg::recip(i_pl);
        end
        if (r_s1) begin
            r_prod <= {32'd0, r_w} * {32'd0, r_m};
        end
        if (r_s2) begin
            r_quot <= n_quot;
            r_rem  <= n_rem[2:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ hdl/genotype_column_partition_cost.sv @@
// ============================================================================
// genotype_column_partition_cost
// Column cost engine: entry records, partition map and per-partition cost
// accumulators held in RAMs, updated by read-modify-write.
// ============================================================================
// Set partitioning handles each column entry in turn: digit split in the divider,
// then entry, map and accumulator RAMs. A cost query sums min(partition_count, 16)
// accumulator rows; the strobe is one cycle.
// Synchronous reset clears config to defaults and marks all accumulators zero.
// The result receiver cannot stall; one command is in flight at a time.
module genotype_column_partition_cost #(
    parameter int MAX_ENTRIES     = gcpc_pkg::MAX_ENTRIES,
    parameter int MAX_PARTITIONS  = gcpc_pkg::MAX_PARTITIONS,
    parameter int MAX_INDIVIDUALS = gcpc_pkg::MAX_INDIVIDUALS,
    parameter int MAX_PLOIDY      = gcpc_pkg::MAX_PLOIDY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [5:0]  i_entry_index,
    input  logic [1:0]  i_allele_kind,
    input  logic [15:0] i_quality,
    input  logic [3:0]  i_individual,
    input  logic [2:0]  i_haplotype,
    input  logic [3:0]  i_partition_index,
    input  logic [31:0] i_partitioning_word,
    input  logic [15:0] i_allele_assignment,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        o_cost_valid,
    output logic [31:0] o_cost
);

    `include "genotype_column_partition_cost_macros.svh"

    localparam int EW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int MAP_D    = MAX_INDIVIDUALS * MAX_PLOIDY;
    localparam int MW       = (MAP_D > 1) ? $clog2(MAP_D) : 1;
    localparam int PW       = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int QMAX     = (MAX_PARTITIONS < 16) ? MAX_PARTITIONS : 16;

    gcpc_pkg::t_state r_state, n_state;

    logic [3:0]  r_ploidy;
    logic [4:0]  r_pcount;
    logic [6:0]  r_clen;

    logic [31:0] r_word;
    logic [8:0]  r_i;
    logic [8:0]  r_n;
    logic        r_flip;
    logic        r_sub;
    logic [2:0]  r_dnew;
    logic [2:0]  r_cur_dig;
    logic [1:0]  r_kind;
    logic [15:0] r_qual;
    logic [3:0]  r_indiv;
    logic [5:0]  r_part;
    logic [MAX_PARTITIONS-1:0] r_acc_vld;
    logic        r_acc_rvld;
    logic [4:0]  r_q;
    logic [4:0]  r_qn;
    logic [15:0] r_assign;
    logic [31:0] r_sum;

    logic        accept;
    logic [3:0]  pl;
    logic [8:0]  eff_len;
    logic [4:0]  q_n;
    logic        flip_ok;
    logic        apply_ok;
    logic        part_ok;
    logic [5:0]  part_ext;
    logic [7:0]  idx8;
    logic [9:0]  map_lin_ld;
    logic [9:0]  map_lin_ap;
    logic [63:0] acc_row;
    logic [31:0] acc_pick;
    logic [31:0] c_wrong;
    logic [31:0] c_match;
    logic [31:0] c_ref;
    logic [31:0] c_alt;
    logic [31:0] n_ref;
    logic [31:0] n_alt;

    logic          ent_we, ent_re;
    logic [EW-1:0] ent_waddr, ent_raddr;
    gcpc_pkg::t_entry ent_wdata, ent_rd;
    logic [24:0]   ent_rdata;
    logic          map_we, map_re;
    logic [MW-1:0] map_waddr, map_raddr;
    logic [3:0]    map_wdata, map_rdata;
    logic          acc_we, acc_re;
    logic [PW-1:0] acc_waddr, acc_raddr;
    logic [63:0]   acc_wdata, acc_rdata;
    logic          div_start, div_done;
    logic [31:0]   div_quot;
    logic [2:0]    div_rem;

    gcpc_ram #(.WIDTH(25), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_re(ent_re), .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    gcpc_ram #(.WIDTH(4), .DEPTH(MAP_D)) u_map_ram (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_re(map_re), .i_raddr(map_raddr), .o_rdata(map_rdata)
    );

    gcpc_ram #(.WIDTH(64), .DEPTH(MAX_PARTITIONS)) u_acc_ram (
        .i_clk(i_clk), .i_we(acc_we), .i_waddr(acc_waddr), .i_wdata(acc_wdata),
        .i_re(acc_re), .i_raddr(acc_raddr), .o_rdata(acc_rdata)
    );

    gcpc_divp u_divp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_word(r_word),
        .i_pl(pl), .o_done(div_done), .o_quot(div_quot), .o_rem(div_rem)
    );

    assign ent_rd      = gcpc_pkg::t_entry'(ent_rdata);
    assign busy        = (r_state != gcpc_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_ploidy == 4'd0) begin
            pl = 4'd1;
        end else if (r_ploidy > 4'(MAX_PLOIDY)) begin
            pl = 4'(MAX_PLOIDY);
        end else begin
            pl = r_ploidy;
        end
        eff_len = ({2'd0, r_clen} > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : {2'd0, r_clen};
        q_n     = (r_pcount > 5'(QMAX)) ? 5'(QMAX) : r_pcount;
        idx8    = {2'd0, i_entry_index};
        flip_ok = ({3'd0, i_entry_index} < eff_len) && ({1'b0, i_haplotype} < pl);
        map_lin_ld = 10'(i_individual) * 10'(MAX_PLOIDY) + 10'(i_haplotype);
        map_lin_ap = 10'(r_indiv) * 10'(MAX_PLOIDY) + 10'(r_cur_dig);
        apply_ok = (r_kind == gcpc_pkg::KIND_REF || r_kind == gcpc_pkg::KIND_ALT)
                   && ({3'd0, r_indiv} < 7'(MAX_INDIVIDUALS))
                   && ({1'b0, r_cur_dig} < 4'(MAX_PLOIDY));
        part_ext = {2'd0, map_rdata};
        part_ok  = (part_ext < 6'(MAX_PARTITIONS));
        // Rows never written since the last clear read as zero.
        acc_row  = r_acc_rvld ? acc_rdata : 64'd0;
        acc_pick = r_assign[r_q[3:0]] ? acc_row[63:32] : acc_row[31:0];
        c_wrong  = {8'd0, r_qual, 8'd0};
        c_match  = {16'd0, gcpc_pkg::match_cost(r_qual)};
        c_ref    = (r_kind == gcpc_pkg::KIND_REF) ? c_match : c_wrong;
        c_alt    = (r_kind == gcpc_pkg::KIND_REF) ? c_wrong : c_match;
        n_ref    = r_sub ? gcpc_pkg::sat_sub(acc_row[31:0], c_ref)
                         : gcpc_pkg::sat_add(acc_row[31:0], c_ref);
        n_alt    = r_sub ? gcpc_pkg::sat_sub(acc_row[63:32], c_alt)
                         : gcpc_pkg::sat_add(acc_row[63:32], c_alt);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcpc_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        gcpc_pkg::OP_SET_PART:
                            n_state = (eff_len == 9'd0) ? gcpc_pkg::S_IDLE
                                                         : gcpc_pkg::S_SETNEXT;
                        gcpc_pkg::OP_FLIP:
                            n_state = flip_ok ? gcpc_pkg::S_EDAT : gcpc_pkg::S_IDLE;
                        gcpc_pkg::OP_GET_COST:
                            n_state = (q_n == 5'd0) ? gcpc_pkg::S_QOUT : gcpc_pkg::S_QRD;
                        default: n_state = gcpc_pkg::S_IDLE;
                    endcase
                end
            end
            gcpc_pkg::S_SETNEXT: n_state = gcpc_pkg::S_DIV;
            gcpc_pkg::S_DIV:     n_state = div_done ? gcpc_pkg::S_EDAT : gcpc_pkg::S_DIV;
            gcpc_pkg::S_EDAT:    n_state = gcpc_pkg::S_MAP;
            gcpc_pkg::S_MAP:     n_state = apply_ok ? gcpc_pkg::S_MAPW : gcpc_pkg::S_PASS;
            gcpc_pkg::S_MAPW:    n_state = part_ok ? gcpc_pkg::S_ACC : gcpc_pkg::S_PASS;
            gcpc_pkg::S_ACC:     n_state = gcpc_pkg::S_PASS;
            gcpc_pkg::S_PASS: begin
                if (r_flip && r_sub) begin
                    n_state = gcpc_pkg::S_MAP;
                end else if (r_flip || (r_i + 9'd1 == r_n)) begin
                    n_state = gcpc_pkg::S_IDLE;
                end else begin
                    n_state = gcpc_pkg::S_SETNEXT;
                end
            end
            gcpc_pkg::S_QRD:
                n_state = (r_q + 5'd1 == r_qn) ? gcpc_pkg::S_QOUT : gcpc_pkg::S_QRD;
            gcpc_pkg::S_QOUT:    n_state = gcpc_pkg::S_IDLE;
            default:             n_state = gcpc_pkg::S_IDLE;
        endcase
    end

    // Memory and unit controls.
    always_comb begin
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_waddr = r_i[EW-1:0];
        ent_raddr = r_i[EW-1:0];
        ent_wdata = '{kind: ent_rd.kind, qual: ent_rd.qual, indiv: ent_rd.indiv,
                      digit: r_dnew};
        map_we    = 1'b0;
        map_re    = 1'b0;
        map_waddr = map_lin_ld[MW-1:0];
        map_raddr = map_lin_ap[MW-1:0];
        map_wdata = i_partition_index;
        acc_we    = 1'b0;
        acc_re    = 1'b0;
        acc_waddr = r_part[PW-1:0];
        acc_raddr = part_ext[PW-1:0];
        acc_wdata = {n_alt, n_ref};
        div_start = 1'b0;
        unique case (r_state)
            gcpc_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        gcpc_pkg::OP_LOAD_ENTRY: begin
                            ent_we    = ({2'd0, i_entry_index} < 8'(MAX_ENTRIES));
                            ent_waddr = idx8[EW-1:0];
                            ent_wdata = '{kind: i_allele_kind, qual: i_quality,
                                          indiv: i_individual, digit: 3'd0};
                        end
                        gcpc_pkg::OP_LOAD_MAP: begin
                            map_we = ({3'd0, i_individual} < 7'(MAX_INDIVIDUALS))
                                     && ({1'b0, i_haplotype} < 4'(MAX_PLOIDY));
                        end
                        gcpc_pkg::OP_FLIP: begin
                            ent_re    = flip_ok;
                            ent_raddr = idx8[EW-1:0];
                        end
                        gcpc_pkg::OP_GET_COST: begin
                            acc_re    = 1'b1;
                            acc_raddr = '0;
                        end
                        default: ;
                    endcase
                end
            end
            gcpc_pkg::S_SETNEXT: begin
                div_start = 1'b1;
                ent_re    = 1'b1;
            end
            gcpc_pkg::S_EDAT:   ent_we = 1'b1;
            gcpc_pkg::S_MAP:    map_re = apply_ok;
            gcpc_pkg::S_MAPW:   acc_re = part_ok;
            gcpc_pkg::S_ACC:    acc_we = 1'b1;
            gcpc_pkg::S_QRD: begin
                acc_re    = (r_q + 5'd1 != r_qn);
                acc_raddr = PW'(r_q + 5'd1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gcpc_pkg::S_IDLE;
            r_ploidy  <= 4'd2;
            r_pcount  <= 5'd4;
            r_clen    <= 7'd0;
            r_acc_vld <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    gcpc_pkg::CFG_PLOIDY:     r_ploidy <= i_cfg_data[3:0];
                    gcpc_pkg::CFG_PART_COUNT: r_pcount <= i_cfg_data[4:0];
                    gcpc_pkg::CFG_COL_LENGTH: r_clen   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == gcpc_pkg::S_IDLE && accept
                && i_opcode == gcpc_pkg::OP_SET_PART) begin
                r_acc_vld <= '0;
            end else if (acc_we) begin
                r_acc_vld[r_part[PW-1:0]] <= 1'b1;
            end
        end

        if (acc_re) begin
            r_acc_rvld <= r_acc_vld[acc_raddr];
        end

        unique case (r_state)
            gcpc_pkg::S_IDLE: begin
                r_word   <= i_partitioning_word;
                r_n      <= eff_len;
                r_i      <= (i_opcode == gcpc_pkg::OP_SET_PART) ? 9'd0
                                                                : {3'd0, i_entry_index};
                r_dnew   <= i_haplotype;
                r_flip   <= (i_opcode == gcpc_pkg::OP_FLIP);
                r_assign <= i_allele_assignment;
                r_qn     <= q_n;
                r_q      <= 5'd0;
                r_sum    <= 32'd0;
            end
            gcpc_pkg::S_DIV: begin
                if (div_done) begin
                    r_word <= div_quot;
                    r_dnew <= div_rem;
                end
            end
            gcpc_pkg::S_EDAT: begin
                r_kind    <= ent_rd.kind;
                r_qual    <= ent_rd.qual;
                r_indiv   <= ent_rd.indiv;
                r_sub     <= r_flip;
                r_cur_dig <= r_flip ? ent_rd.digit : r_dnew;
            end
            gcpc_pkg::S_MAPW: r_part <= part_ext;
            gcpc_pkg::S_PASS: begin
                if (r_flip && r_sub) begin
                    r_sub     <= 1'b0;
                    r_cur_dig <= r_dnew;
                end else begin
                    r_i <= r_i + 9'd1;
                end
            end
            gcpc_pkg::S_QRD: begin
                r_sum <= gcpc_pkg::sat_add(r_sum, acc_pick);
                r_q   <= r_q + 5'd1;
            end
            default: ;
        endcase
    end

    assign o_cost_valid = (r_state == gcpc_pkg::S_QOUT);
    assign o_cost       = r_sum;

    `GCPC_ASSERT_NEXT(a_strobe_single, o_cost_valid, !o_cost_valid)
    `GCPC_ASSERT_NEXT(a_query_busy, accept && i_opcode == gcpc_pkg::OP_GET_COST, busy)
    `GCPC_ASSERT_SAME(a_div_in_wait, div_done, r_state == gcpc_pkg::S_DIV)
    `GCPC_ASSERT_SAME(a_no_acc_write_in_query, r_state == gcpc_pkg::S_QRD, !acc_we)

endmodule

@@ tb/sv/gcpc_cost_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gcpc_cost_checker
// Watches the command, register and cost channels of the column cost engine,
// keeps its own copy of the entry records, partition map and accumulators,
// predicts each cost result and compares it with what the engine returns.
// ============================================================================
module gcpc_cost_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [5:0]  i_entry_index,
    input  logic [1:0]  i_allele_kind,
    input  logic [15:0] i_quality,
    input  logic [3:0]  i_individual,
    input  logic [2:0]  i_haplotype,
    input  logic [3:0]  i_partition_index,
    input  logic [31:0] i_partitioning_word,
    input  logic [15:0] i_allele_assignment,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        o_cost_valid,
    input  logic [31:0] o_cost,
    output int          fail_count,
    output int          pending_count
);

    localparam logic [15:0] PHRED_MATCH [34] = '{
        16'd10240, 16'd1758, 16'd1108, 16'd773, 16'd564, 16'd423, 16'd322, 16'd247,
        16'd192, 16'd150, 16'd117, 16'd92, 16'd72, 16'd57, 16'd45, 16'd36,
        16'd28, 16'd22, 16'd18, 16'd14, 16'd11, 16'd9, 16'd7, 16'd6,
        16'd4, 16'd4, 16'd3, 16'd2, 16'd2, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1
    };

    logic [1:0]  rec_kind [gcpc_pkg::MAX_ENTRIES];
    logic [15:0] rec_qual [gcpc_pkg::MAX_ENTRIES];
    logic [3:0]  rec_indiv [gcpc_pkg::MAX_ENTRIES];
    logic [2:0]  rec_digit [gcpc_pkg::MAX_ENTRIES];
    logic [3:0]  part_of [gcpc_pkg::MAX_INDIVIDUALS * gcpc_pkg::MAX_PLOIDY];
    logic [31:0] allele_cost [2 * gcpc_pkg::MAX_PARTITIONS];
    logic [3:0]  ploidy_reg;
    logic [4:0]  part_count_reg;
    logic [6:0]  col_len_reg;
    logic [31:0] cost_expected [$];

    function automatic int used_ploidy();
        if (ploidy_reg == 4'd0) return 1;
        if (int'(ploidy_reg) > gcpc_pkg::MAX_PLOIDY) return gcpc_pkg::MAX_PLOIDY;
        return int'(ploidy_reg);
    endfunction

    function automatic int used_length();
        return (int'(col_len_reg) > gcpc_pkg::MAX_ENTRIES) ? gcpc_pkg::MAX_ENTRIES
                                                           : int'(col_len_reg);
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Adds or removes one entry's two costs at the partition its digit maps to.
    function automatic void charge_entry(int idx, int digit, bit add);
        int part;
        logic [31:0] wrong, match, c_ref, c_alt;
        if (rec_kind[idx] != gcpc_pkg::KIND_REF && rec_kind[idx] != gcpc_pkg::KIND_ALT)
            return;
        part = int'(part_of[int'(rec_indiv[idx]) * gcpc_pkg::MAX_PLOIDY + digit]);
        if (part >= gcpc_pkg::MAX_PARTITIONS) return;
        wrong = {8'd0, rec_qual[idx], 8'd0};
        match = (rec_qual[idx] < 16'd34) ? {16'd0, PHRED_MATCH[rec_qual[idx]]} : 32'd0;
        c_ref = (rec_kind[idx] == gcpc_pkg::KIND_REF) ? match : wrong;
        c_alt = (rec_kind[idx] == gcpc_pkg::KIND_REF) ? wrong : match;
        if (add) begin
            allele_cost[2*part]   = add_sat(allele_cost[2*part], c_ref);
            allele_cost[2*part+1] = add_sat(allele_cost[2*part+1], c_alt);
        end else begin
            allele_cost[2*part]   = (allele_cost[2*part] > c_ref) ?
                                    allele_cost[2*part] - c_ref : 32'd0;
            allele_cost[2*part+1] = (allele_cost[2*part+1] > c_alt) ?
                                    allele_cost[2*part+1] - c_alt : 32'd0;
        end
    endfunction

    function automatic void predict_command();
        int pl, n;
        logic [31:0] w, sum;
        case (i_opcode)
            gcpc_pkg::OP_LOAD_ENTRY: begin
                rec_kind[i_entry_index]  = i_allele_kind;
                rec_qual[i_entry_index]  = i_quality;
                rec_indiv[i_entry_index] = i_individual;
                rec_digit[i_entry_index] = '0;
            end
            gcpc_pkg::OP_LOAD_MAP:
                part_of[int'(i_individual) * gcpc_pkg::MAX_PLOIDY + int'(i_haplotype)] =
                    i_partition_index;
            gcpc_pkg::OP_SET_PART: begin
                foreach (allele_cost[k]) allele_cost[k] = '0;
                pl = used_ploidy();
                n = used_length();
                w = i_partitioning_word;
                for (int i = 0; i < n; i++) begin
                    rec_digit[i] = 3'(w % 32'(pl));
                    w = w / 32'(pl);
                    charge_entry(i, int'(rec_digit[i]), 1'b1);
                end
            end
            gcpc_pkg::OP_FLIP: begin
                if (int'(i_entry_index) < used_length()
                    && int'(i_haplotype) < used_ploidy()) begin
                    charge_entry(int'(i_entry_index), int'(rec_digit[i_entry_index]), 1'b0);
                    charge_entry(int'(i_entry_index), int'(i_haplotype), 1'b1);
                    rec_digit[i_entry_index] = i_haplotype;
                end
            end
            gcpc_pkg::OP_GET_COST: begin
                n = (part_count_reg > 5'd16) ? 16 : int'(part_count_reg);
                sum = '0;
                for (int i = 0; i < n; i++)
                    sum = add_sat(sum, allele_cost[2*i + int'(i_allele_assignment[i])]);
                cost_expected.push_back(sum);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: cost mismatch: %s", $time, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ploidy_reg = 4'd2;
            part_count_reg = 5'd4;
            col_len_reg = 7'd0;
            foreach (allele_cost[k]) allele_cost[k] = '0;
            cost_expected.delete();
        end else begin
            // The engine is idle while registers change, so order does not matter.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gcpc_pkg::CFG_PLOIDY:     ploidy_reg = i_cfg_data[3:0];
                    gcpc_pkg::CFG_PART_COUNT: part_count_reg = i_cfg_data[4:0];
                    gcpc_pkg::CFG_COL_LENGTH: col_len_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_cost_valid) begin
                if (cost_expected.size() == 0)
                    report_mismatch($sformatf("unexpected cost %h", o_cost));
                else if (o_cost !== cost_expected[0])
                    report_mismatch($sformatf("got %h, want %h", o_cost, cost_expected[0]));
                if (cost_expected.size() != 0) void'(cost_expected.pop_front());
            end
            if (start && !busy) predict_command();
        end
        pending_count = cost_expected.size();
    end

endmodule

@@ tb/sv/genotype_column_partition_cost_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// genotype_column_partition_cost_tb
// Drives the column cost engine with directed corner commands and phases of
// random commands under varied register settings; a checker beside the engine
// predicts and compares every cost transfer.
// ============================================================================
module genotype_column_partition_cost_tb;

    localparam int SETTLE_CYCLES = 700;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_opcode;
    logic [5:0]  i_entry_index;
    logic [1:0]  i_allele_kind;
    logic [15:0] i_quality;
    logic [3:0]  i_individual;
    logic [2:0]  i_haplotype;
    logic [3:0]  i_partition_index;
    logic [31:0] i_partitioning_word;
    logic [15:0] i_allele_assignment;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        o_cost_valid;
    logic [31:0] o_cost;
    int          fail_count;
    int          pending_count;
    int          col_len;
    bit          allow_gaps;

    genotype_column_partition_cost u_dut (.*);
    gcpc_cost_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("genotype_column_partition_cost_tb failed");
        $finish;
    end

    // Called at a falling edge with the fields staged. Presents the command,
    // waits for the edge that takes it and returns at the next falling edge.
    task automatic issue(logic [2:0] op);
        if (allow_gaps && $urandom_range(0, 5) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        start = 1'b1;
        i_opcode = op;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_all_costs();
        start = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] data);
        wait_all_costs();
        while (busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(int pl, int pc, int len);
        write_reg(gcpc_pkg::CFG_PLOIDY, pl[6:0]);
        write_reg(gcpc_pkg::CFG_PART_COUNT, pc[6:0]);
        write_reg(gcpc_pkg::CFG_COL_LENGTH, len[6:0]);
        col_len = len;
    endtask

    task automatic load_entry(int idx, logic [1:0] kind, logic [15:0] q, logic [3:0] ind);
        i_entry_index = idx[5:0];
        i_allele_kind = kind;
        i_quality = q;
        i_individual = ind;
        issue(gcpc_pkg::OP_LOAD_ENTRY);
    endtask

    task automatic load_map(logic [3:0] ind, logic [2:0] hap, logic [3:0] part);
        i_individual = ind;
        i_haplotype = hap;
        i_partition_index = part;
        issue(gcpc_pkg::OP_LOAD_MAP);
    endtask

    task automatic set_part(logic [31:0] w);
        i_partitioning_word = w;
        issue(gcpc_pkg::OP_SET_PART);
    endtask

    task automatic flip(int idx, logic [2:0] hap);
        i_entry_index = idx[5:0];
        i_haplotype = hap;
        issue(gcpc_pkg::OP_FLIP);
    endtask

    task automatic query(logic [15:0] assign_bits);
        i_allele_assignment = assign_bits;
        issue(gcpc_pkg::OP_GET_COST);
    endtask

    task automatic random_command();
        int r;
        r = $urandom_range(0, 99);
        i_entry_index = 6'($urandom);
        i_allele_kind = 2'($urandom);
        i_quality = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
        i_individual = 4'($urandom);
        i_haplotype = 3'($urandom);
        i_partition_index = 4'($urandom);
        i_partitioning_word = $urandom;
        i_allele_assignment = 16'($urandom);
        if (r < 32) begin
            // Mostly flip entries inside the column so they take effect.
            if (col_len > 0 && $urandom_range(0, 4) != 0)
                i_entry_index = 6'($urandom_range(0, (col_len > 64 ? 64 : col_len) - 1));
            issue(gcpc_pkg::OP_FLIP);
        end else if (r < 55) issue(gcpc_pkg::OP_GET_COST);
        else if (r < 67) issue(gcpc_pkg::OP_SET_PART);
        else if (r < 82) issue(gcpc_pkg::OP_LOAD_ENTRY);
        else if (r < 95) issue(gcpc_pkg::OP_LOAD_MAP);
        else issue(3'($urandom_range(5, 7)));
    endtask

    initial begin
        start = 1'b0;
        i_opcode = gcpc_pkg::OP_LOAD_ENTRY;
        i_entry_index = '0;
        i_allele_kind = '0;
        i_quality = '0;
        i_individual = '0;
        i_haplotype = '0;
        i_partition_index = '0;
        i_partitioning_word = '0;
        i_allele_assignment = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = gcpc_pkg::CFG_PLOIDY;
        i_cfg_data = '0;
        col_len = 0;
        allow_gaps = 1'b1;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every record and map word is written before anything reads it.
        for (int i = 0; i < gcpc_pkg::MAX_ENTRIES; i++)
            load_entry(i, 2'($urandom_range(1, 2)), 16'($urandom_range(0, 60)),
                       4'($urandom));
        for (int i = 0; i < gcpc_pkg::MAX_INDIVIDUALS; i++)
            for (int h = 0; h < gcpc_pkg::MAX_PLOIDY; h++)
                load_map(4'(i), 3'(h), 4'($urandom));

        // Directed corners: quality extremes, blank and unused kinds, register extremes.
        load_entry(0, 2'd1, 16'd0, 4'd0);
        load_entry(1, 2'd2, 16'd33, 4'd15);
        load_entry(2, 2'd1, 16'd34, 4'd3);
        load_entry(3, 2'd2, 16'd255, 4'd7);
        load_entry(4, 2'd1, 16'd256, 4'd1);
        load_entry(5, 2'd2, 16'hFFFF, 4'd2);
        load_entry(6, 2'd0, 16'd20, 4'd4);
        load_entry(7, 2'd3, 16'd5, 4'd5);
        load_map(4'd15, 3'd7, 4'd15);
        load_map(4'd0, 3'd0, 4'd0);
        set_part(32'hFFFF_FFFF);
        query(16'h0000);
        query(16'hFFFF);
        issue(3'd5);
        issue(3'd6);
        issue(3'd7);
        set_regs(8, 16, 64);
        set_part(32'hDEAD_BEEF);
        flip(63, 3'd7);
        flip(0, 3'd0);
        query(16'hA5A5);
        set_regs(15, 31, 127);
        set_part(32'h1234_5678);
        flip(63, 3'd6);
        query(16'h5A5A);
        set_regs(0, 0, 8);
        set_part(32'hFFFF_FFFF);
        flip(9, 3'd0);
        flip(2, 3'd1);
        query(16'hFFFF);
        set_regs(3, 1, 0);
        set_part(32'hFFFF_FFFF);
        flip(0, 3'd1);
        query(16'h0001);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_regs(2, 4, 16);
                1: set_regs(1, 16, 64);
                2: set_regs(8, 17, 40);
                3: set_regs(7, 8, 32);
                default: set_regs($urandom_range(0, 15), $urandom_range(0, 31),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(1, 24));
            endcase
            if (ph >= 8) allow_gaps = 1'b0;
            set_part($urandom);
            for (int n = 0; n < 150; n++) begin
                if (ph == 3 && n == 75) wait_all_costs();
                random_command();
            end
        end

        wait_all_costs();
        while (busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("genotype_column_partition_cost_tb passed");
        end else begin
            $display("genotype_column_partition_cost_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/gcpc_pkg.sv
hdl/gcpc_ram.sv
hdl/gcpc_divp.sv
hdl/genotype_column_partition_cost.sv
tb/sv/gcpc_cost_checker.sv
tb/sv/genotype_column_partition_cost_tb.sv
